// ----- hdl/bsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, constants and the character classifier for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // ASCII codes of the alphabet edges
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    // byte counts carried by a job
    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       message_last;
    } item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_done;
    } result_t;

    // One accepted character's worth of output: up to three bytes, MSB first.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        has_bytes;
        logic        done;
    } job_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t r;
        r.bad   = 1'b0;
        r.value = 6'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            r.value = 6'(ch - CH_UPPER_A);
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            r.value = 6'(ch - CH_LOWER_A + 8'd26);
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
            r.value = 6'(ch - CH_DIGIT_0 + 8'd52);
        else if (ch == CH_PLUS)
            r.value = 6'd62;
        else if (ch == CH_SLASH)
            r.value = 6'd63;
        else
            r.bad = 1'b1;
        return r;
    endfunction

endpackage

// ----- hdl/bsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_front
// Classifies each character, gathers sextets and issues byte jobs.
// ----------------------------------------------------------------------------
module bsd_front
    import bsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output logic  job_push,
    output job_t  job
);

    logic [1:0]  group_count_reg, group_count_next;
    logic [17:0] store_reg, store_next;
    logic        stopped_reg, stopped_next;

    sextet_t     sx;
    logic        take;
    logic        full_group;
    logic [1:0]  gc_mid;
    logic [17:0] store_mid;

    always_comb
    begin
        sx         = sextet_of(item.char_code);
        take       = !stopped_reg && !sx.bad;
        full_group = take && (group_count_reg == 2'd3);

        stopped_next = stopped_reg || sx.bad;
        gc_mid       = group_count_reg;
        store_mid    = store_reg;
        if (full_group)
        begin
            gc_mid    = 2'd0;
            store_mid = 18'd0;
        end
        else if (take)
        begin
            gc_mid    = group_count_reg + 2'd1;
            store_mid = {store_reg[11:0], sx.value};
        end

        job.word      = 24'd0;
        job.nbytes    = NBYTES_ONE;
        job.has_bytes = 1'b0;
        job.done      = item.message_last;
        if (full_group)
        begin
            job.word      = {store_reg, sx.value};
            job.nbytes    = NBYTES_THREE;
            job.has_bytes = 1'b1;
        end
        else if (gc_mid == 2'd3)
        begin
            job.word      = {store_mid, 6'd0};
            job.nbytes    = NBYTES_TWO;
            job.has_bytes = 1'b1;
        end
        else if (gc_mid == 2'd2)
        begin
            job.word      = {store_mid[11:0], 12'd0};
            job.nbytes    = NBYTES_ONE;
            job.has_bytes = 1'b1;
        end
        job_push = accept && (full_group || item.message_last);

        group_count_next = gc_mid;
        store_next       = store_mid;
        if (item.message_last)
        begin
            group_count_next = 2'd0;
            store_next       = 18'd0;
            stopped_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= 2'd0;
            store_reg       <= 18'd0;
            stopped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            group_count_reg <= group_count_next;
            store_reg       <= store_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

// ----- hdl/bsd_job_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_job_fifo
// Short job queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module bsd_job_fifo
    import bsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    job_t                 slot_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + JOB_PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + JOB_PTR_W'(rd_en);
        count_next  = count_reg + JOB_CNT_W'(wr_en) - JOB_CNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/bsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_back
// Steps through the head job one byte per transfer.
// ----------------------------------------------------------------------------
module bsd_back
    import bsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  logic    job_empty,
    input  logic    pop,
    output logic    job_pop,
    output result_t result
);

    logic [1:0] idx_reg, idx_next;
    logic       last_byte;
    logic       xfer;

    always_comb
    begin
        last_byte = (idx_reg == job.nbytes - 2'd1);
        xfer      = pop && !job_empty;
        job_pop   = xfer && last_byte;

        case (idx_reg)
            2'd0:    result.data_byte = job.word[23:16];
            2'd1:    result.data_byte = job.word[15:8];
            2'd2:    result.data_byte = job.word[7:0];
            default: result.data_byte = 8'd0;
        endcase
        result.byte_valid   = job.has_bytes;
        result.run_last     = last_byte;
        result.message_done = last_byte && job.done;

        idx_next = idx_reg;
        if (job_pop)
            idx_next = 2'd0;
        else if (xfer)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ----- hdl/base64_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, up to three bytes out.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  -------   -----------------   --------------------------------------------
//  item      push / full         char_code, message_last
//  result    pop / empty         data_byte, byte_valid, run_last, message_done
//
//  A character is classified and folded into the group in the cycle it is
//  transferred; the bytes it yields are queued as one job (4 deep).
//  The emitter gives one byte per cycle while pop is high and the queue holds a job;
//  sustained, one character per cycle while pop stays high (4 chars -> 3 bytes).
//  full rises only when the job queue holds 4 jobs; stalls on pop back up there.
//  Reset (rst_n, async) clears the group state, the queue and the byte index.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
    import bsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic accept;
    logic job_push;
    job_t job_in;
    job_t job_head;
    logic job_pop;
    logic job_full;
    logic job_empty;

    // An item transfer needs a free job slot even if it yields no bytes.
    assign full   = job_full;
    assign accept = push && !job_full;
    assign empty  = job_empty;

    bsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (job_in)
    );

    bsd_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (job_pop),
        .rd_job (job_head),
        .full   (job_full),
        .empty  (job_empty)
    );

    // Head job drives the result ports directly; the index picks the byte.
    bsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .pop       (pop),
        .job_pop   (job_pop),
        .result    (result)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream decoder core. A driver pushes
// characters from a pending queue, a decode predictor builds the expected
// byte stream, and a monitor pops results and compares every field.
// ----------------------------------------------------------------------------
module tb_top
    import bsd_pkg::*;
();

    localparam int          CLK_HALF     = 6;
    localparam int          RANDOM_ITEMS = 375;
    localparam int          IDLE_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int          DRAIN_CYCLES = 32;    // 4 jobs x 3 bytes, with margin
    localparam int          LONG_HOLD    = 90;    // receiver back-pressure stretch
    localparam int          HOLD_STEP    = 150;   // results between long holds
    localparam int          MAX_REPORTS  = 10;
    localparam logic [7:0]  CH_EQUALS    = 8'h3d;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    full;
    item_t   item  = '0;
    logic    empty;
    logic    pop   = 1'b0;
    result_t result;

    base64_stream_decoder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decode predictor state: partial group, held sextets, halted flag.
    // ------------------------------------------------------------------------
    logic [1:0]  grp_cnt;
    logic [17:0] sextet_acc;
    bit          decoding_halted;

    item_t       pending_chars[$];   // characters not yet offered
    result_t     expected_bytes[$];  // predicted results, oldest first

    int unsigned error_count   = 0;
    int unsigned report_count  = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_mark     = 80;
    int unsigned idle_cycles   = 0;

    // {bad, sextet} for one character
    function automatic logic [6:0] sextet_code(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {1'b0, 6'(c - CH_UPPER_A)};
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {1'b0, 6'(c - CH_LOWER_A + 26)};
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b0, 6'(c - CH_DIGIT_0 + 52)};
        if (c == CH_PLUS)  return {1'b0, 6'd62};
        if (c == CH_SLASH) return {1'b0, 6'd63};
        return {1'b1, 6'd0};
    endfunction

    function automatic logic [7:0] sextet_char(input int unsigned idx);
        if (idx < 26) return 8'(CH_UPPER_A + idx);
        if (idx < 52) return 8'(CH_LOWER_A + idx - 26);
        if (idx < 62) return 8'(CH_DIGIT_0 + idx - 52);
        if (idx == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic void clear_group();
        grp_cnt         = '0;
        sextet_acc      = '0;
        decoding_halted = 1'b0;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic valid);
        result_t r;
        r              = '0;
        r.data_byte    = b;
        r.byte_valid   = valid;
        expected_bytes.push_back(r);
    endfunction

    // One transferred character: fold it into the group, queue what it yields.
    function automatic void predict_decode(input item_t ch);
        logic [6:0]  code;
        logic [23:0] word;
        int          n;
        n    = 0;
        code = sextet_code(ch.char_code);
        if (!decoding_halted)
        begin
            if (code[6])
            begin
                decoding_halted = 1'b1;   // padding and junk both stop decoding
            end
            else if (grp_cnt == 2'd3)
            begin
                word = {sextet_acc, code[5:0]};
                queue_byte(word[23:16], 1'b1);
                queue_byte(word[15:8], 1'b1);
                queue_byte(word[7:0], 1'b1);
                n          = 3;
                grp_cnt    = '0;
                sextet_acc = '0;
            end
            else
            begin
                sextet_acc = {sextet_acc[11:0], code[5:0]};
                grp_cnt    = grp_cnt + 2'd1;
            end
        end
        if (ch.message_last)
        begin
            // partial group of k sextets gives k-1 bytes; a lone sextet is dropped
            if (grp_cnt >= 2'd2)
            begin
                word = {6'd0, sextet_acc} << (6 * (4 - int'(grp_cnt)));
                queue_byte(word[23:16], 1'b1);
                n++;
                if (grp_cnt == 2'd3)
                begin
                    queue_byte(word[15:8], 1'b1);
                    n++;
                end
            end
            if (n == 0)
            begin
                queue_byte(8'd0, 1'b0);  // message ends with nothing left to give
                n = 1;
            end
            expected_bytes[$].message_done = 1'b1;
            clear_group();
        end
        if (n > 0)
            expected_bytes[$].run_last = 1'b1;
    endfunction

    function automatic void report_miss(input string what, input result_t exp_r,
                                        input result_t got_r);
        error_count++;
        if (report_count < MAX_REPORTS)
        begin
            report_count++;
            $display("[%0t] %s: exp %02h v%0b rl%0b md%0b, got %02h v%0b rl%0b md%0b",
                     $realtime, what, exp_r.data_byte, exp_r.byte_valid, exp_r.run_last,
                     exp_r.message_done, got_r.data_byte, got_r.byte_valid,
                     got_r.run_last, got_r.message_done);
        end
    endfunction

    function automatic void compare_byte(input result_t got_r);
        result_t exp_r;
        results_seen++;
        if (expected_bytes.size() == 0)
        begin
            report_miss("unexpected result", '0, got_r);
            return;
        end
        exp_r = expected_bytes.pop_front();
        if (got_r.data_byte    !== exp_r.data_byte    ||
            got_r.byte_valid   !== exp_r.byte_valid   ||
            got_r.run_last     !== exp_r.run_last     ||
            got_r.message_done !== exp_r.message_done)
            report_miss("result mismatch", exp_r, got_r);
    endfunction

    // Gap length: mostly zero or short, now and then long. A calm stretch
    // forces back-to-back activity for a while.
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers pending characters; prediction happens on each transfer.
    // push and item are held while full is high.
    // ------------------------------------------------------------------------
    int unsigned tx_gap  = 0;
    int unsigned tx_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push   <= 1'b0;
            item   <= '0;
            tx_gap <= 0;
        end
        else
        begin
            if (push && !full)
                predict_decode(item);
            if (push && full)
            begin
                // stalled: keep offering the same character
            end
            else if (tx_gap != 0)
            begin
                push   <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending_chars.size() != 0)
            begin
                item   <= pending_chars.pop_front();
                push   <= 1'b1;
                tx_gap <= next_gap(tx_calm);
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: pops with random gaps; every HOLD_STEP results it holds pop
    // low for a long stretch so the job queue fills and full backs up.
    // ------------------------------------------------------------------------
    int unsigned rx_wait = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_draw;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            if (pop && !empty)
                compare_byte(result);
            if (rx_wait != 0)
            begin
                pop     <= 1'b0;
                rx_wait <= rx_wait - 1;
            end
            else if (results_seen >= hold_mark)
            begin
                pop       <= 1'b0;
                rx_wait   <= LONG_HOLD;
                hold_mark <= hold_mark + HOLD_STEP;
            end
            else
            begin
                rx_draw = next_gap(rx_calm);
                if (rx_draw == 0)
                begin
                    pop <= 1'b1;
                end
                else
                begin
                    pop     <= 1'b0;
                    rx_wait <= rx_draw - 1;
                end
            end
        end
    end

    // Watchdog: a run with no transfer on either side for too long is hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_char(input logic [7:0] c, input logic last);
        item_t it;
        it.char_code    = c;
        it.message_last = last;
        pending_chars.push_back(it);
    endtask

    // whole message, last flag on its final character
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    initial
    begin
        item_t       msg[$];
        item_t       it;
        int unsigned kind;
        int unsigned len;
        logic [7:0]  c;
        logic [6:0]  sx;

        clear_group();

        // Directed part
        add_text("TWFu");       // full group closing the message
        add_text("TWE=");       // three sextets then padding: two bytes
        add_text("TQ==");       // two sextets then padding: one byte
        add_text("Q");          // lone sextet dropped, empty done result
        add_text("=");          // padding only: no bytes left
        add_char(8'h00, 1'b1);  // invalid low extreme
        add_char(8'hff, 1'b1);  // invalid high extreme
        add_text("+/09azAZ");   // alphabet edges, a full group mid-message
        add_text("Zm!v");       // invalid stops decoding, later chars ignored

        // Random part: mostly well-formed messages, some broken, some noise
        while (pending_chars.size() < 28 + RANDOM_ITEMS)
        begin
            msg.delete();
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                : $urandom_range(0, 12);
            if (kind < 85)
            begin
                for (int i = 0; i < len; i++)
                begin
                    it.char_code    = sextet_char($urandom_range(0, 63));
                    it.message_last = 1'b0;
                    msg.push_back(it);
                end
            end
            if (kind < 70)
            begin
                // optional padding
                for (int p = $urandom_range(0, 3); p > 1; p--)
                begin
                    it.char_code    = CH_EQUALS;
                    it.message_last = 1'b0;
                    msg.push_back(it);
                end
            end
            else if (kind < 85)
            begin
                // broken: one non-alphabet character, then anything
                if ($urandom_range(0, 3) == 0)
                begin
                    c = CH_EQUALS;
                end
                else
                begin
                    do
                    begin
                        c  = 8'($urandom_range(0, 255));
                        sx = sextet_code(c);
                    end while (!sx[6]);
                end
                it.char_code    = c;
                it.message_last = 1'b0;
                msg.push_back(it);
                for (int i = $urandom_range(0, 5); i > 0; i--)
                begin
                    it.char_code = 8'($urandom_range(0, 255));
                    msg.push_back(it);
                end
            end
            else
            begin
                // noise: raw bytes of any value
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    it.char_code    = 8'($urandom_range(0, 255));
                    it.message_last = 1'b0;
                    msg.push_back(it);
                end
            end
            if (msg.size() == 0)
            begin
                it.char_code    = sextet_char($urandom_range(0, 63));
                it.message_last = 1'b0;
                msg.push_back(it);
            end
            msg[$].message_last = 1'b1;
            foreach (msg[i])
                pending_chars.push_back(msg[i]);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every character transferred, every byte received, then a quiet drain
        while (pending_chars.size() != 0 || push)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bytes.size() != 0)
        begin
            error_count += expected_bytes.size();
            $display("%0d expected results never arrived", expected_bytes.size());
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
